// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, request codes and pipeline control for the complex ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int unsigned PartWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned ReqTypeWidth = 3;

  // request codes
  typedef enum logic [ReqTypeWidth-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONJ = 3'd5,
    OP_CMP  = 3'd6,
    OP_NONE = 3'd7
  } req_e;

  // control that travels beside the datapath
  typedef struct packed {
    logic valid;
    logic is_div;
    logic div_zero;
    logic is_equal;
    logic have;
    logic neg_r;
    logic neg_i;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/complex_arithmetic_unit.sv =====
// Registers in order from input to output: product stage, sum stage, divider cells, output register.
// One request per cycle unless output stalls; the one-bit divider cells move as a whole.
// The product stage, sum stage, divider cells and output register all advance on one enable.
// Reset clears all valid bits at once; payload registers are not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, negate,
// conjugate and compare with saturation, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int unsigned PART_WIDTH = PartWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  localparam int unsigned InW  = 4*PART_WIDTH,
  localparam int unsigned OutW = ((2*PART_WIDTH+3+7)/8)*8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  wire logic [InW-1:0]  s_axis_tdata,
  // req_type
  input  wire logic [ReqTypeWidth-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // result_real, result_imag, is_equal, div_zero, overflowed, zero fill
  output logic [OutW-1:0]      m_axis_tdata
);

  localparam int unsigned W  = PART_WIDTH;
  localparam int unsigned NW = 2*W+FRAC_BITS;
  localparam int unsigned DW = 2*W;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // product and sum stages
  ctrl_t         ctrl_f;
  logic [NW-1:0] mag_r_f, mag_i_f;
  logic [DW-1:0] den_f;

  cau_front #(.W(W), .F(FRAC_BITS), .NW(NW), .DW(DW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .a_real_i   (s_axis_tdata[W-1:0]),
    .a_imag_i   (s_axis_tdata[2*W-1:W]),
    .b_real_i   (s_axis_tdata[3*W-1:2*W]),
    .b_imag_i   (s_axis_tdata[4*W-1:3*W]),
    .ctrl_o     (ctrl_f),
    .mag_r_o    (mag_r_f),
    .mag_i_o    (mag_i_f),
    .den_o      (den_f)
  );

  // divider chain, one quotient bit per cell, both parts side by side
  ctrl_t         ctrl_c [NW+1];
  logic [NW-1:0] num_r [NW+1], num_i [NW+1], quo_r [NW+1], quo_i [NW+1];
  logic [DW-1:0] rem_r [NW+1], rem_i [NW+1], den_r [NW+1], den_i [NW+1];

  assign ctrl_c[0] = ctrl_f;
  assign num_r[0]  = mag_r_f;
  assign num_i[0]  = mag_i_f;
  assign den_r[0]  = den_f;
  assign den_i[0]  = den_f;
  assign rem_r[0]  = '0;
  assign rem_i[0]  = '0;
  assign quo_r[0]  = '0;
  assign quo_i[0]  = '0;

  for (genvar k = 0; k < NW; k++) begin : g_chain
    cau_cell #(.DW(DW), .NW(NW), .BIT(NW-1-k)) u_cell_r (
      .clk_i (clk_i), .en_i (en),
      .num_i (num_r[k]), .den_i (den_r[k]), .rem_i (rem_r[k]), .quo_i (quo_r[k]),
      .num_o (num_r[k+1]), .den_o (den_r[k+1]), .rem_o (rem_r[k+1]), .quo_o (quo_r[k+1])
    );
    cau_cell #(.DW(DW), .NW(NW), .BIT(NW-1-k)) u_cell_i (
      .clk_i (clk_i), .en_i (en),
      .num_i (num_i[k]), .den_i (den_i[k]), .rem_i (rem_i[k]), .quo_i (quo_i[k]),
      .num_o (num_i[k+1]), .den_o (den_i[k+1]), .rem_o (rem_i[k+1]), .quo_o (quo_i[k+1])
    );

    // control beside each cell
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_c[k+1] <= '0;
      end else if (en) begin
        ctrl_c[k+1] <= ctrl_c[NW > 0 ? k : 0];
      end
    end
  end

  // saturation and output register
  ctrl_t         ce;
  logic [NW-1:0] sel_r, sel_i, lim_r, lim_i, sat_r, sat_i;
  logic          ovf_r, ovf_i, ovf;
  logic [W-1:0]  res_r, res_i;

  always_comb begin
    ce    = ctrl_c[NW];
    sel_r = ce.is_div ? quo_r[NW] : num_r[NW];
    sel_i = ce.is_div ? quo_i[NW] : num_i[NW];
    lim_r = (NW'(1) << (W-1)) - NW'(!ce.neg_r);
    lim_i = (NW'(1) << (W-1)) - NW'(!ce.neg_i);
    ovf_r = sel_r > lim_r;
    ovf_i = sel_i > lim_i;
    sat_r = ovf_r ? lim_r : sel_r;
    sat_i = ovf_i ? lim_i : sel_i;
    res_r = ce.neg_r ? -sat_r[W-1:0] : sat_r[W-1:0];
    res_i = ce.neg_i ? -sat_i[W-1:0] : sat_i[W-1:0];
    ovf   = ce.have && !ce.div_zero && (ovf_r || ovf_i);
    if (!ce.have || ce.div_zero) begin
      res_r = '0;
      res_i = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= ce.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= OutW'({ovf, ce.div_zero, ce.is_equal, res_i, res_r});
    end
  end

  // flags are exclusive, and flagged non-results carry zero parts
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2*W+2] && (m_axis_tdata[2*W+1] || m_axis_tdata[2*W])))
    else $error("overflow raised with another flag");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2*W+1]) |-> (m_axis_tdata[2*W-1:0] == '0))
    else $error("divide by zero with nonzero result");

  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2*W]) |-> (m_axis_tdata[2*W-1:0] == '0))
    else $error("compare with nonzero result");

endmodule

`default_nettype wire

// ===== sv/cau_cell.sv =====
// ----------------------------------------------------------------------------
// cau_cell
// One restoring-division cell: decides one quotient bit and passes on.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_cell #(
  parameter int unsigned DW  = 64,
  parameter int unsigned NW  = 80,
  parameter int unsigned BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] quo_i,
  output logic      [NW-1:0] num_o,
  output logic      [DW-1:0] den_o,
  output logic      [DW-1:0] rem_o,
  output logic      [NW-1:0] quo_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] quo_d;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    trial = {rem_i, num_i[BIT]};
    diff  = trial - (DW+1)'(den_i);
    ge    = (trial >= (DW+1)'(den_i));
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = quo_i;
    quo_d[BIT] = ge;
  end

  // hand over to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i;
      den_o <= den_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Product stage and sum stage: signs, magnitudes and divisor for the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front
  import cau_pkg::*;
#(
  parameter int unsigned W  = PartWidthDef,
  parameter int unsigned F  = FracBitsDef,
  parameter int unsigned NW = 2*W+F,
  parameter int unsigned DW = 2*W
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [ReqTypeWidth-1:0] req_type_i,
  input  wire logic signed [W-1:0] a_real_i,
  input  wire logic signed [W-1:0] a_imag_i,
  input  wire logic signed [W-1:0] b_real_i,
  input  wire logic signed [W-1:0] b_imag_i,
  output ctrl_t                    ctrl_o,
  output logic [NW-1:0]            mag_r_o,
  output logic [NW-1:0]            mag_i_o,
  output logic [DW-1:0]            den_o
);

  localparam int unsigned XW = 2*W+1;
  localparam int unsigned PW = 2*W;

  // first stage: operands and products
  logic              v1_q;
  req_e              op1_q;
  logic signed [W-1:0]  ar_q, ai_q, br_q, bi_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= req_e'(req_type_i);
      ar_q   <= a_real_i;
      ai_q   <= a_imag_i;
      br_q   <= b_real_i;
      bi_q   <= b_imag_i;
      p_rr_q <= PW'(a_real_i) * PW'(b_real_i);
      p_ii_q <= PW'(a_imag_i) * PW'(b_imag_i);
      p_ri_q <= PW'(a_real_i) * PW'(b_imag_i);
      p_ir_q <= PW'(a_imag_i) * PW'(b_real_i);
      p_bb_q <= PW'(b_real_i) * PW'(b_real_i);
      p_cc_q <= PW'(b_imag_i) * PW'(b_imag_i);
    end
  end

  // second stage: signed value per part, then sign and magnitude
  logic signed [XW-1:0] wr, wi;
  logic [XW-1:0] abs_r, abs_i;
  ctrl_t         ctrl_d;
  logic [NW-1:0] mag_r_d, mag_i_d;

  always_comb begin
    wr = '0;
    wi = '0;
    ctrl_d = '0;
    ctrl_d.valid = v1_q;
    ctrl_d.have  = 1'b1;
    unique case (op1_q)
      OP_ADD: begin
        wr = XW'(ar_q) + XW'(br_q);
        wi = XW'(ai_q) + XW'(bi_q);
      end
      OP_SUB: begin
        wr = XW'(ar_q) - XW'(br_q);
        wi = XW'(ai_q) - XW'(bi_q);
      end
      OP_MUL: begin
        wr = XW'(p_rr_q) - XW'(p_ii_q);
        wi = XW'(p_ri_q) + XW'(p_ir_q);
      end
      OP_DIV: begin
        wr = XW'(p_rr_q) + XW'(p_ii_q);
        wi = XW'(p_ir_q) - XW'(p_ri_q);
        ctrl_d.is_div   = 1'b1;
        ctrl_d.div_zero = (br_q == '0) && (bi_q == '0);
      end
      OP_NEG: begin
        wr = -XW'(ar_q);
        wi = -XW'(ai_q);
      end
      OP_CONJ: begin
        wr = XW'(ar_q);
        wi = -XW'(ai_q);
      end
      OP_CMP: begin
        ctrl_d.have     = 1'b0;
        ctrl_d.is_equal = (ar_q == br_q) && (ai_q == bi_q);
      end
      default: begin
        ctrl_d.have = 1'b0;
      end
    endcase
    ctrl_d.neg_r = wr[XW-1];
    ctrl_d.neg_i = wi[XW-1];
    abs_r = wr[XW-1] ? XW'(-wr) : XW'(wr);
    abs_i = wi[XW-1] ? XW'(-wi) : XW'(wi);
    case (op1_q)
      OP_MUL: begin
        mag_r_d = NW'(abs_r >> F);
        mag_i_d = NW'(abs_i >> F);
      end
      OP_DIV: begin
        mag_r_d = NW'(abs_r) << F;
        mag_i_d = NW'(abs_i) << F;
      end
      default: begin
        mag_r_d = NW'(abs_r);
        mag_i_d = NW'(abs_i);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_o <= '0;
    end else if (en_i) begin
      ctrl_o <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_r_o <= mag_r_d;
      mag_i_o <= mag_i_d;
      den_o   <= DW'(p_bb_q) + DW'(p_cc_q);
    end
  end

endmodule

`default_nettype wire
